/* rtl/pftb_pkg.sv */
`timescale 1ns / 1ps
// Package for the palette fog/tint blend unit: configuration and pipeline
// stage types, register indexes and shared arithmetic helpers. No dependencies.
package pftb_pkg;

  // Palette size: entries at or above this index pass through untouched
  localparam int PALETTE_ENTRIES = 256;

  localparam logic [7:0]  ALPHA_OPAQUE   = 8'd255;
  localparam logic [7:0]  FOG_ALPHA_RST  = 8'd180;
  localparam logic [15:0] OPAQUE_COLOR   = 16'h0001;
  localparam logic [4:0]  CHAN_MAX       = 5'h1F;
  localparam logic [23:0] REMAP_MAX_IDENT = 24'hFFFFFF;
  localparam logic [23:0] REMAP_MIN_IDENT = 24'h000000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FOG_ENABLE   = 3'd0,
    CFG_TINT_MODE    = 3'd1,
    CFG_FOG_COLOR    = 3'd2,
    CFG_FOG_ALPHA    = 3'd3,
    CFG_TINT_COLOR_A = 3'd4,
    CFG_TINT_ALPHA   = 3'd5,
    CFG_TINT_COLOR_B = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        fog_enable;
    logic        tint_mode;
    logic [23:0] fog_color;
    logic [7:0]  fog_alpha;
    logic [23:0] tint_color_a;
    logic [7:0]  tint_alpha;
    logic [23:0] tint_color_b;
  } cfg_t;

  // Stage 1: source beat plus fog/tint mix numerators
  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  index;
    logic [15:0] sum_r;
    logic [15:0] sum_g;
    logic [15:0] sum_b;
    logic [15:0] sum_a;
  } s1_t;

  // Stage 2: lerp products, remap result and selection flags
  typedef struct packed {
    logic [15:0]        color;
    logic [7:0]         index;
    logic               active;
    logic               tinted;
    logic               remap_sel;
    logic               opaque;
    logic signed [14:0] prod_r;
    logic signed [14:0] prod_g;
    logic signed [14:0] prod_b;
    logic [15:0]        remap_color;
  } s2_t;

  // f*(255-a) + t*a, at most 255*255 so it fits 16 bits
  function automatic logic [15:0] mix_sum(input logic [7:0] f, input logic [7:0] t,
                                          input logic [7:0] a);
    logic [16:0] s;
    s = 17'(f) * 17'(ALPHA_OPAQUE - a) + 17'(t) * 17'(a);
    return s[15:0];
  endfunction

  // floor(x/255) for x <= 65025 without a divider
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // (mn>>3) + ((ch*mx)>>8), saturated at 31
  function automatic logic [4:0] remap5(input logic [4:0] ch, input logic [7:0] mx,
                                        input logic [7:0] mn);
    logic [12:0] p;
    logic [5:0]  v;
    p = 13'(ch) * 13'(mx);
    v = 6'(mn[7:3]) + 6'(p[12:8]);
    return (v > 6'(CHAN_MAX)) ? CHAN_MAX : v[4:0];
  endfunction

  // c + p/256 with the quotient truncated toward zero, kept to 5 bits
  function automatic logic [4:0] lerp_finish(input logic [4:0] c,
                                             input logic signed [14:0] p);
    logic signed [14:0] adj;
    logic [6:0]         s;
    adj = p + (p[14] ? 15'sd255 : 15'sd0);
    s   = 7'(c) + 7'(adj[14:8]);
    return s[4:0];
  endfunction

endpackage

/* rtl/palette_fog_tint_blend_top.sv */
`timescale 1ns / 1ps
// Top level of the palette fog/tint blend unit: config registers plus a
// three-stage datapath. Depends on pftb_pkg and the pftb_* modules.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one RGBA5551 palette entry
//   and its index per beat; output channel (out_valid / out_stall) returns
//   the tinted entry, the index and the tint-active flag, one beat per input
//   beat, in order.
//   A beat passes through the three registered stages (mix numerators,
//   target select and lerp products, truncating finish) before out_valid
//   rises. Throughput: one beat per clock while out_stall is low.
//   Each stage holds its beat while the next one cannot take it, so in_stall rises
//   only once all three stages hold beats and out_stall is high; bubbles
//   close up while the output is stalled.
//   Config writes (cfg_we, cfg_index, cfg_wdata) take effect at the next
//   edge; write them only while no beat is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults: everything zero except fog alpha = 180.
module palette_fog_tint_blend_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_palette_color,
  input  logic [7:0]  in_palette_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_tinted_color,
  output logic [7:0]  out_entry_index,
  output logic        out_tint_active
);
  import pftb_pkg::*;

  cfg_t cfg;
  s1_t  s1_data;
  s2_t  s2_data;
  logic s1_valid;
  logic s2_valid;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  pftb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pftb_mix_stage u_mix (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .up_valid      (in_valid),
    .up_ready      (s1_ready),
    .palette_color (in_palette_color),
    .palette_index (in_palette_index),
    .dn_valid      (s1_valid),
    .dn_ready      (s2_ready),
    .dn_data       (s1_data)
  );

  pftb_lerp_stage u_lerp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  pftb_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (s2_valid),
    .up_ready         (s3_ready),
    .up_data          (s2_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tinted_color (out_tinted_color),
    .out_entry_index  (out_entry_index),
    .out_tint_active  (out_tint_active)
  );

  assign in_stall = !s1_ready;

endmodule

/* rtl/pftb_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file for the palette fog/tint blend unit.
// Depends on pftb_pkg.
module pftb_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_wdata,
  output pftb_pkg::cfg_t      cfg
);
  import pftb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FOG_ENABLE:   cfg_nxt.fog_enable   = cfg_wdata[0];
        CFG_TINT_MODE:    cfg_nxt.tint_mode    = cfg_wdata[0];
        CFG_FOG_COLOR:    cfg_nxt.fog_color    = cfg_wdata;
        CFG_FOG_ALPHA:    cfg_nxt.fog_alpha    = cfg_wdata[7:0];
        CFG_TINT_COLOR_A: cfg_nxt.tint_color_a = cfg_wdata;
        CFG_TINT_ALPHA:   cfg_nxt.tint_alpha   = cfg_wdata[7:0];
        CFG_TINT_COLOR_B: cfg_nxt.tint_color_b = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fog_enable   <= 1'b0;
      cfg_r.tint_mode    <= 1'b0;
      cfg_r.fog_color    <= '0;
      cfg_r.fog_alpha    <= FOG_ALPHA_RST;
      cfg_r.tint_color_a <= '0;
      cfg_r.tint_alpha   <= '0;
      cfg_r.tint_color_b <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/pftb_mix_stage.sv */
`timescale 1ns / 1ps
// Stage 1: input register; captures the source beat with the fog/tint mix
// numerators (two 8x8 products per channel). Depends on pftb_pkg.
module pftb_mix_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  pftb_pkg::cfg_t cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  logic [15:0]    palette_color,
  input  logic [7:0]     palette_index,
  output logic           dn_valid,
  input  logic           dn_ready,
  output pftb_pkg::s1_t  dn_data
);
  import pftb_pkg::*;

  logic valid_r;
  logic valid_nxt;
  s1_t  data_r;
  s1_t  data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Mix numerators depend only on configuration
  always_comb begin
    data_nxt.color = palette_color;
    data_nxt.index = palette_index;
    data_nxt.sum_r = mix_sum(cfg.fog_color[23:16], cfg.tint_color_a[23:16], cfg.tint_alpha);
    data_nxt.sum_g = mix_sum(cfg.fog_color[15:8], cfg.tint_color_a[15:8], cfg.tint_alpha);
    data_nxt.sum_b = mix_sum(cfg.fog_color[7:0], cfg.tint_color_a[7:0], cfg.tint_alpha);
    data_nxt.sum_a = mix_sum(cfg.fog_alpha, cfg.tint_alpha, cfg.tint_alpha);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* rtl/pftb_lerp_stage.sv */
`timescale 1ns / 1ps
// Stage 2: target selection (/255 blend), activity decode, lerp products and
// the complete remap result. Depends on pftb_pkg.
module pftb_lerp_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  pftb_pkg::cfg_t cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  pftb_pkg::s1_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output pftb_pkg::s2_t  dn_data
);
  import pftb_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  s2_t               data_r;
  s2_t               data_nxt;
  logic              fog;
  logic              lerp;
  logic              blend;
  logic              in_pal;
  logic [7:0]        t_r;
  logic [7:0]        t_g;
  logic [7:0]        t_b;
  logic [7:0]        t_a;
  logic [4:0]        c_r;
  logic [4:0]        c_g;
  logic [4:0]        c_b;
  logic signed [5:0] d_r;
  logic signed [5:0] d_g;
  logic signed [5:0] d_b;

  assign up_ready = !valid_r || dn_ready;

  assign fog    = cfg.fog_enable;
  assign lerp   = (cfg.tint_alpha != '0);
  assign blend  = !((cfg.tint_color_a == REMAP_MAX_IDENT) &&
                    (cfg.tint_color_b == REMAP_MIN_IDENT));
  assign in_pal = (int'(up_data.index) < PALETTE_ENTRIES);

  assign c_r = up_data.color[15:11];
  assign c_g = up_data.color[10:6];
  assign c_b = up_data.color[5:1];

  // Lerp target: fog, tint, or their /255 blend
  always_comb begin
    if (fog && lerp) begin
      t_r = div255(up_data.sum_r);
      t_g = div255(up_data.sum_g);
      t_b = div255(up_data.sum_b);
      t_a = div255(up_data.sum_a);
    end else if (fog) begin
      t_r = cfg.fog_color[23:16];
      t_g = cfg.fog_color[15:8];
      t_b = cfg.fog_color[7:0];
      t_a = cfg.fog_alpha;
    end else begin
      t_r = cfg.tint_color_a[23:16];
      t_g = cfg.tint_color_a[15:8];
      t_b = cfg.tint_color_a[7:0];
      t_a = cfg.tint_alpha;
    end
  end

  // Signed channel distance toward the 5-bit target
  assign d_r = $signed({1'b0, t_r[7:3]}) - $signed({1'b0, c_r});
  assign d_g = $signed({1'b0, t_g[7:3]}) - $signed({1'b0, c_g});
  assign d_b = $signed({1'b0, t_b[7:3]}) - $signed({1'b0, c_b});

  always_comb begin
    data_nxt.color       = up_data.color;
    data_nxt.index       = up_data.index;
    data_nxt.remap_sel   = cfg.tint_mode;
    data_nxt.active      = cfg.tint_mode ? (fog || blend) : (fog || lerp);
    data_nxt.tinted      = data_nxt.active && in_pal;
    data_nxt.opaque      = (t_a == ALPHA_OPAQUE);
    data_nxt.prod_r      = d_r * $signed({1'b0, t_a});
    data_nxt.prod_g      = d_g * $signed({1'b0, t_a});
    data_nxt.prod_b      = d_b * $signed({1'b0, t_a});
    data_nxt.remap_color = {remap5(c_r, cfg.tint_color_a[23:16], cfg.tint_color_b[23:16]),
                            remap5(c_g, cfg.tint_color_a[15:8], cfg.tint_color_b[15:8]),
                            remap5(c_b, cfg.tint_color_a[7:0], cfg.tint_color_b[7:0]),
                            1'b1};
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* rtl/pftb_out_stage.sv */
`timescale 1ns / 1ps
// Stage 3: finishes the lerp (truncating /256), picks the final entry and
// holds it in the output register. Depends on pftb_pkg.
module pftb_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  pftb_pkg::s2_t  up_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    out_tinted_color,
  output logic [7:0]     out_entry_index,
  output logic           out_tint_active
);
  import pftb_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  logic [15:0] color_r;
  logic [15:0] color_nxt;
  logic [7:0]  index_r;
  logic        active_r;
  logic [15:0] lerp_color;

  assign up_ready = !valid_r || !out_stall;

  assign lerp_color = {lerp_finish(up_data.color[15:11], up_data.prod_r),
                       lerp_finish(up_data.color[10:6], up_data.prod_g),
                       lerp_finish(up_data.color[5:1], up_data.prod_b),
                       1'b1};

  // Final entry select
  always_comb begin
    if (!up_data.tinted) begin
      color_nxt = up_data.color;
    end else if (up_data.remap_sel) begin
      color_nxt = up_data.remap_color;
    end else if (up_data.opaque) begin
      color_nxt = OPAQUE_COLOR;
    end else begin
      color_nxt = lerp_color;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      color_r  <= color_nxt;
      index_r  <= up_data.index;
      active_r <= up_data.active;
    end
  end

  assign out_valid        = valid_r;
  assign out_tinted_color = color_r;
  assign out_entry_index  = index_r;
  assign out_tint_active  = active_r;

endmodule
